/* design/tsrs_pkg.sv */
`timescale 1ns / 1ps

package tsrs_pkg;

    // input command codes; code 3 is unused and ignored
    typedef enum logic [1:0] {
        CMD_TX    = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // step inside the clear-screen escape sequence
    typedef enum logic [1:0] {
        CLR_ESC   = 2'd0,
        CLR_BRKT  = 2'd1,
        CLR_TWO   = 2'd2,
        CLR_FINAL = 2'd3
    } clr_phase_t;

    // step between rows (cr, lf) and inside the home sequence (esc, '[', 'H')
    typedef enum logic [1:0] {
        SEND_FIRST  = 2'd0,
        SEND_SECOND = 2'd1,
        SEND_THIRD  = 2'd2
    } send_phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [1:0] row_sel;
        logic [3:0] column_sel;
        logic [7:0] char_in;
    } item_t;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_ESC   = 8'h1b;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TWO   = 8'h32;
    localparam logic [7:0] BYTE_CAP_H = 8'h48;
    localparam logic [7:0] BYTE_CAP_J = 8'h4a;
    localparam logic [7:0] BYTE_LBRKT = 8'h5b;

endpackage

/* design/tsrs_ram.sv */
`timescale 1ns / 1ps

module tsrs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/tsrs_seq.sv */
`timescale 1ns / 1ps

module tsrs_seq import tsrs_pkg::*; #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  item_t      item,
    output logic [7:0] tx_byte
);

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam logic [ROW_W-1:0] ROW_LIM  = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LIM  = COL_W'(COLUMNS);

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    send_phase_t       send_phase_reg, send_phase_next;
    clr_phase_t        clr_phase_reg, clr_phase_next;
    logic              clr_pend_reg, clr_pend_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DEPTH-1:0]  valid_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;

    logic              is_tx, wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        ram_q, win_char;

    assign is_tx = fire && (item.cmd == CMD_TX);
    assign wr_en = fire && (item.cmd == CMD_WRITE)
                && (32'(item.row_sel) < ROWS) && (32'(item.column_sel) < COLUMNS);
    assign wr_addr = ADDR_W'(32'(item.row_sel) * COLUMNS + 32'(item.column_sel));

    // read follows the position the sequencer will hold after this edge
    assign addr_next = ADDR_W'(32'(row_next) * COLUMNS + 32'(col_next));

    assign win_char = fwd_hit_reg ? fwd_data_reg
                    : (valid_reg[addr_reg] ? ram_q : BYTE_SPACE);

    tsrs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.char_in),
        .rd_addr (addr_next),
        .rd_data (ram_q)
    );

    // next state
    always_comb begin
        row_next        = row_reg;
        col_next        = col_reg;
        send_phase_next = send_phase_reg;
        clr_phase_next  = clr_phase_reg;
        clr_pend_next   = clr_pend_reg;
        if (fire && (item.cmd == CMD_CLEAR)) begin
            clr_pend_next = 1'b1;
        end else if (is_tx) begin
            if (clr_pend_reg) begin
                case (clr_phase_reg)
                    CLR_ESC:  clr_phase_next = CLR_BRKT;
                    CLR_BRKT: clr_phase_next = CLR_TWO;
                    CLR_TWO:  clr_phase_next = CLR_FINAL;
                    default: begin
                        clr_phase_next = CLR_ESC;
                        clr_pend_next  = 1'b0;
                    end
                endcase
            end else if (row_reg < ROW_LIM) begin
                if (col_reg < COL_LIM) begin
                    col_next = col_reg + COL_W'(1);
                end else if (row_reg < ROW_LAST) begin
                    if (send_phase_reg == SEND_FIRST) begin
                        send_phase_next = SEND_SECOND;
                    end else begin
                        row_next        = row_reg + ROW_W'(1);
                        col_next        = '0;
                        send_phase_next = SEND_FIRST;
                    end
                end else begin
                    row_next = ROW_LIM;
                    col_next = '0;
                end
            end else begin
                case (send_phase_reg)
                    SEND_FIRST:  send_phase_next = SEND_SECOND;
                    SEND_SECOND: send_phase_next = SEND_THIRD;
                    default: begin
                        send_phase_next = SEND_FIRST;
                        row_next        = '0;
                        col_next        = '0;
                    end
                endcase
            end
        end
    end

    // byte for the current transmit slot
    always_comb begin
        tx_byte = BYTE_NUL;
        if (clr_pend_reg) begin
            case (clr_phase_reg)
                CLR_ESC:  tx_byte = BYTE_ESC;
                CLR_BRKT: tx_byte = BYTE_LBRKT;
                CLR_TWO:  tx_byte = BYTE_TWO;
                default:  tx_byte = BYTE_CAP_J;
            endcase
        end else if (row_reg < ROW_LIM) begin
            if (col_reg < COL_LIM) begin
                tx_byte = win_char;
            end else if (row_reg < ROW_LAST) begin
                tx_byte = (send_phase_reg == SEND_FIRST) ? BYTE_CR : BYTE_LF;
            end else begin
                tx_byte = BYTE_NUL;
            end
        end else begin
            case (send_phase_reg)
                SEND_FIRST:  tx_byte = BYTE_ESC;
                SEND_SECOND: tx_byte = BYTE_LBRKT;
                default:     tx_byte = BYTE_CAP_H;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= ROW_LIM;
            col_reg        <= '0;
            send_phase_reg <= SEND_FIRST;
            clr_phase_reg  <= CLR_ESC;
            clr_pend_reg   <= 1'b1;
            addr_reg       <= '0;
            valid_reg      <= '0;
            fwd_hit_reg    <= 1'b0;
        end else begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            send_phase_reg <= send_phase_next;
            clr_phase_reg  <= clr_phase_next;
            clr_pend_reg   <= clr_pend_next;
            addr_reg       <= addr_next;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            // ram read returns pre-write data on a same-address collision
            fwd_hit_reg    <= wr_en && (wr_addr == addr_next);
        end
        fwd_data_reg <= item.char_in;
    end

endmodule

/* design/terminal_screen_refresh_sequencer_top.sv */
`timescale 1ns / 1ps

// terminal screen refresh sequencer: mirrors a ROWS x COLUMNS text window onto a serial
// terminal. command 0 (transmit slot) returns the next byte to send: a pending clear
// goes out first as esc '[' '2' 'J', otherwise the window characters row by row with
// cr lf between rows, a zero byte after the last row, then esc '[' 'H' before row 0
// again. command 1 writes one window character, command 2 requests a clear, command 3
// is ignored; only command 0 produces a result transfer. one item is accepted every
// clock cycle while no transmit slot is stalled on the output; a byte passes from the
// input register through the sequencer logic into the result register. the window sits
// in a ram that is read every cycle at the next refresh position, with write forwarding;
// per-entry valid flops make unwritten entries read as space right after reset, so
// there is no clearing pass and no startup delay.

module terminal_screen_refresh_sequencer_top import tsrs_pkg::*; #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row_sel[1:0], column_sel[5:2], char_in[13:6], zero pad
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // tx_byte[7:0]
);

    // input register
    logic       in_valid_reg;
    item_t      in_item_reg;
    // result register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;

    logic       is_tx;
    logic       fire;
    logic [7:0] tx_byte;
    item_t      s_item;

    assign s_item.cmd        = cmd_t'(s_tuser);
    assign s_item.row_sel    = s_tdata[1:0];
    assign s_item.column_sel = s_tdata[5:2];
    assign s_item.char_in    = s_tdata[13:6];

    // a transmit slot advances only when the result register can take its byte
    assign is_tx    = (in_item_reg.cmd == CMD_TX);
    assign fire     = in_valid_reg && (!is_tx || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    tsrs_seq #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .tx_byte (tx_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire && is_tx) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        if (fire && is_tx) begin
            out_byte_reg <= tx_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

    // a result only ever comes from a transmit slot
    a_result_from_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(fire && is_tx))
        else $error("result transfer without a transmit slot");

    // a stalled transmit slot blocks new input transfers
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && is_tx && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while a transmit slot is stalled");

    // write, clear and unused commands never load the result register
    a_no_result_from_other: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !is_tx) |=> (m_tvalid == $past(m_tvalid && !m_tready)))
        else $error("non-transmit command produced a result");

endmodule
